### hw/rtl/cor_pkg.sv
// Shared types and constants of the circle octant rasterizer.
// Used by cor_cell_index and circle_octant_rasterizer; depends on nothing.
package cor_pkg;

	// Field widths
	localparam int COORD_W  = 12;
	localparam int RADIUS_W = 10;
	localparam int DIM_W    = 10;
	localparam int GLYPH_W  = 8;
	localparam int COLOR_W  = 24;
	localparam int INDEX_W  = 20;
	localparam int STEPX_W  = 11;
	localparam int DEC_W    = 24;
	// Mirrored cell position before the index is formed
	localparam int POS_W    = 14;
	// Signed linear index before the bounds check
	localparam int LIN_W    = 26;

	localparam int IN_TDATA_W  = 96;
	localparam int OUT_TDATA_W = 80;

	// Command codes carried in the slave tuser
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// Configuration register indices
	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	localparam logic [DIM_W-1:0]   WIDTH_RESET  = DIM_W'(80);
	localparam logic [DIM_W-1:0]   HEIGHT_RESET = DIM_W'(25);
	localparam logic [INDEX_W-1:0] LIMIT_RESET  = INDEX_W'(80 * 25);

	// Attributes that travel with one cell request down the index pipeline
	typedef struct packed {
		logic [GLYPH_W-1:0] glyph;
		logic [COLOR_W-1:0] fg;
		logic [COLOR_W-1:0] bg;
		logic               last;
		logic               done;
		logic               dead;
	} cor_attr_t;

endpackage

### hw/rtl/cor_cell_index.sv
// Cell index pipeline: registers a mirrored cell position, forms the linear
// index and checks it against the screen, ending in the output register. Uses cor_pkg.
module cor_cell_index (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic signed [cor_pkg::POS_W-1:0]  col,
	input  logic signed [cor_pkg::POS_W-1:0]  row,
	input  cor_pkg::cor_attr_t                attr,
	input  logic [cor_pkg::DIM_W-1:0]         screen_width,
	input  logic [cor_pkg::INDEX_W-1:0]       cell_limit,
	output logic                              adv,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [cor_pkg::INDEX_W-1:0]       cell_index,
	output logic                              write_enable,
	output cor_pkg::cor_attr_t                out_attr
);
	import cor_pkg::*;

	logic                    valid_s1, valid_s2, out_valid_q;
	logic signed [POS_W-1:0] col_s1, row_s1;
	cor_attr_t               attr_s1, attr_s2, attr_q;
	logic [LIN_W-1:0]        lin_s2;
	logic [LIN_W-1:0]        row_ext, col_ext, width_ext, lin_next;
	logic                    in_screen;
	logic [INDEX_W-1:0]      index_q;
	logic                    we_q;

	// The whole pipeline moves whenever the output register can take a request.
	assign adv = !out_valid_q || out_ready;

	// Row times stride plus column, modulo 2^LIN_W; the true value always fits.
	assign row_ext   = {{(LIN_W-POS_W){row_s1[POS_W-1]}}, row_s1};
	assign col_ext   = {{(LIN_W-POS_W){col_s1[POS_W-1]}}, col_s1};
	assign width_ext = {{(LIN_W-DIM_W){1'b0}}, screen_width};
	assign lin_next  = LIN_W'(row_ext * width_ext) + col_ext;

	// Inside the screen when non-negative, not dead and below width times height.
	assign in_screen = !lin_s2[LIN_W-1] && !attr_s2.dead &&
		(lin_s2[LIN_W-2:0] < {{(LIN_W-1-INDEX_W){1'b0}}, cell_limit});

	// Valid bits of the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	// Payload of the stages
	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1  <= col;
			row_s1  <= row;
			attr_s1 <= attr;
			lin_s2  <= lin_next;
			attr_s2 <= attr_s1;
			index_q <= in_screen ? lin_s2[INDEX_W-1:0] : '0;
			we_q    <= in_screen;
			attr_q  <= attr_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign cell_index   = index_q;
	assign write_enable = we_q;
	assign out_attr     = attr_q;

endmodule

### hw/rtl/circle_octant_rasterizer.sv
// Top level of the circle octant rasterizer: command decode, circle state,
// eight-way cell sequencer and configuration. Uses cor_pkg and cor_cell_index.
//
// Usage:
// Commands arrive on the s_axis channel; tuser selects start (0) or step (1).
// A start latches centre, radius, glyph and colours and produces no output.
// Each step produces eight cell requests on m_axis, one per cycle unless m_axis
// stalls, the eighth with tlast; tuser carries the done flag, set on all eight
// requests of the step that ends the circle. A step with no circle in progress
// produces one empty request with tlast and done set.
// The circle decision is kept as a running error term, so a step updates the
// state in the cycle it is accepted. The sequencer takes a step only as it emits
// the last cell of the one before (one cell for a step with no circle); a start
// also waits for it to reach its last cell. A step's first request passes the
// snapshot, the registered position, the index multiply and the bounds check. When
// m_axis stalls, the whole index pipeline holds and s_axis_tready drops once the
// sequencer has a step waiting. Reset clears the circle state and sets the screen
// to 80 by 25. The user must write registers on cfg_wr_en only while idle: unchecked.
module circle_octant_rasterizer (
	input  logic                                clk,
	input  logic                                arst_n,
	// center_x[11:0], center_y[23:12], radius[33:24], glyph[41:34],
	// fg_color[65:42], bg_color[89:66], zero fill
	input  logic [cor_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// command[0]
	input  logic                                s_axis_tuser,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// cell_index[19:0], write_enable[20], out_glyph[28:21], out_fg[52:29],
	// out_bg[76:53], zero fill
	output logic [cor_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// done_res[0]
	output logic                                m_axis_tuser,
	output logic                                m_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic                                cfg_wr_en,
	input  logic                                cfg_index,
	input  logic [cor_pkg::DIM_W-1:0]           cfg_wdata
);
	import cor_pkg::*;

	// Unpacked input fields
	logic signed [COORD_W-1:0] in_cx, in_cy;
	logic [RADIUS_W-1:0]       in_radius;
	logic [GLYPH_W-1:0]        in_glyph;
	logic [COLOR_W-1:0]        in_fg, in_bg;

	// Configuration
	logic [DIM_W-1:0]   width_q, height_q;
	logic [INDEX_W-1:0] limit_q;

	// Circle state
	logic                      busy_q;
	logic [STEPX_W-1:0]        step_x_q;
	logic signed [COORD_W-1:0] step_y_q;
	logic signed [DEC_W-1:0]   dec_q;
	logic signed [COORD_W-1:0] cx_q, cy_q;
	logic [GLYPH_W-1:0]        glyph_q;
	logic [COLOR_W-1:0]        fg_q, bg_q;

	// Sequencer snapshot of one step
	logic                      snap_valid_q;
	logic [2:0]                cnt_q;
	logic                      snap_dead_q, snap_fin_q;
	logic signed [COORD_W-1:0] snap_x_q, snap_y_q, snap_cx_q, snap_cy_q;
	logic [GLYPH_W-1:0]        snap_glyph_q;
	logic [COLOR_W-1:0]        snap_fg_q, snap_bg_q;

	logic                      accept, take_step, adv, emit, snap_last;
	logic signed [COORD_W-1:0] x_ext, x_inc, y_dec;
	logic                      fin;
	logic signed [COORD_W-1:0] off_a, off_b;
	logic signed [POS_W-1:0]   col, row, off_col, off_row;
	cor_attr_t                 attr, out_attr;
	logic [INDEX_W-1:0]        cell_index;
	logic                      write_enable;

	assign in_cx     = s_axis_tdata[11:0];
	assign in_cy     = s_axis_tdata[23:12];
	assign in_radius = s_axis_tdata[33:24];
	assign in_glyph  = s_axis_tdata[41:34];
	assign in_fg     = s_axis_tdata[65:42];
	assign in_bg     = s_axis_tdata[89:66];

	// Screen size registers; width times height is kept ready for the bounds check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			limit_q  <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH: begin
					width_q <= cfg_wdata;
					limit_q <= INDEX_W'(cfg_wdata) * INDEX_W'(height_q);
				end
				REG_SCREEN_HEIGHT: begin
					height_q <= cfg_wdata;
					limit_q  <= INDEX_W'(width_q) * INDEX_W'(cfg_wdata);
				end
				default: ;
			endcase
		end
	end

	// Handshake: a new request enters once the sequencer is free or emits its last cell.
	assign snap_last     = snap_dead_q || (cnt_q == 3'd7);
	assign emit          = snap_valid_q && adv;
	assign s_axis_tready = !snap_valid_q || (adv && snap_last);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign take_step     = accept && (s_axis_tuser == CMD_STEP);

	// Next position: the error term says whether x advances or y retreats.
	assign x_ext = {1'b0, step_x_q};
	assign x_inc = x_ext + COORD_W'(1);
	assign y_dec = step_y_q - COORD_W'(1);
	assign fin   = dec_q[DEC_W-1] ? (x_inc >= step_y_q) : y_dec[COORD_W-1];

	// Circle state. The error term is x^2 + (y-1)^2 - r^2.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			step_x_q <= '0;
			step_y_q <= '0;
			dec_q    <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
			glyph_q  <= '0;
			fg_q     <= '0;
			bg_q     <= '0;
		end else if (accept) begin
			if (s_axis_tuser == CMD_START) begin
				busy_q   <= (in_radius != '0);
				step_x_q <= '0;
				step_y_q <= COORD_W'(in_radius);
				dec_q    <= DEC_W'(1) - DEC_W'({in_radius, 1'b0});
				cx_q     <= in_cx;
				cy_q     <= in_cy;
				glyph_q  <= in_glyph;
				fg_q     <= in_fg;
				bg_q     <= in_bg;
			end else if (busy_q) begin
				if (fin) begin
					busy_q <= 1'b0;
				end
				if (dec_q[DEC_W-1]) begin
					step_x_q <= x_inc[STEPX_W-1:0];
					dec_q    <= dec_q + DEC_W'({x_ext, 1'b0}) + DEC_W'(1);
				end else begin
					step_y_q <= y_dec;
					dec_q    <= dec_q + DEC_W'(3)
						- DEC_W'({{(DEC_W-COORD_W-1){step_y_q[COORD_W-1]}}, step_y_q, 1'b0});
				end
			end
		end
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_q <= 1'b0;
			cnt_q        <= '0;
		end else if (take_step) begin
			snap_valid_q <= 1'b1;
			cnt_q        <= '0;
		end else if (emit) begin
			if (snap_last) begin
				snap_valid_q <= 1'b0;
			end
			cnt_q <= cnt_q + 3'd1;
		end
	end

	// Sequencer snapshot; a step with no circle becomes one empty request.
	always_ff @(posedge clk) begin
		if (take_step) begin
			snap_dead_q  <= !busy_q;
			snap_fin_q   <= !busy_q || fin;
			snap_x_q     <= x_ext;
			snap_y_q     <= step_y_q;
			snap_cx_q    <= cx_q;
			snap_cy_q    <= cy_q;
			snap_glyph_q <= busy_q ? glyph_q : '0;
			snap_fg_q    <= busy_q ? fg_q : '0;
			snap_bg_q    <= busy_q ? bg_q : '0;
		end
	end

	// Mirror selection: bit 2 swaps the axes, bit 1 negates the column offset,
	// bit 0 negates the row offset. Column offsets are doubled for cell aspect.
	assign off_a   = cnt_q[2] ? snap_y_q : snap_x_q;
	assign off_b   = cnt_q[2] ? snap_x_q : snap_y_q;
	assign off_col = {off_a[COORD_W-1], off_a, 1'b0};
	assign off_row = POS_W'(off_b);
	assign col = cnt_q[1] ? (POS_W'(snap_cx_q) - off_col) : (POS_W'(snap_cx_q) + off_col);
	assign row = cnt_q[0] ? (POS_W'(snap_cy_q) - off_row) : (POS_W'(snap_cy_q) + off_row);

	assign attr.glyph = snap_glyph_q;
	assign attr.fg    = snap_fg_q;
	assign attr.bg    = snap_bg_q;
	assign attr.last  = snap_last;
	assign attr.done  = snap_fin_q;
	assign attr.dead  = snap_dead_q;

	cor_cell_index u_cell_index (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (snap_valid_q),
		.col          (col),
		.row          (row),
		.attr         (attr),
		.screen_width (width_q),
		.cell_limit   (limit_q),
		.adv          (adv),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.cell_index   (cell_index),
		.write_enable (write_enable),
		.out_attr     (out_attr)
	);

	// Pack the result request
	assign m_axis_tdata = {3'b000, out_attr.bg, out_attr.fg, out_attr.glyph,
		write_enable, cell_index};
	assign m_axis_tuser = out_attr.done;
	assign m_axis_tlast = out_attr.last;

endmodule

### tb/sv/tb_circle_octant_rasterizer.sv
// Self-checking testbench for circle_octant_rasterizer: a behavioural model of the
// circle state predicts each cell request; random stalls on both stream sides.
// Depends on cor_pkg and the circle_octant_rasterizer RTL only.
module tb_circle_octant_rasterizer;
	import cor_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 12;
	localparam int PHASE_ITEMS  = 55;

	// One expected or observed cell request
	typedef struct packed {
		logic [INDEX_W-1:0] idx;
		logic               wr;
		logic [GLYPH_W-1:0] glyph;
		logic [COLOR_W-1:0] fg;
		logic [COLOR_W-1:0] bg;
		logic               tail;
		logic               fin;
	} cell_req_t;

	logic                   clk;
	logic                   arst_n;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   m_axis_tlast;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic                   cfg_wr_en;
	logic                   cfg_index;
	logic [DIM_W-1:0]       cfg_wdata;

	// Screen size and circle state as the block should hold them
	int        scr_width    = 80;
	int        scr_height   = 25;
	bit        circ_active  = 1'b0;
	longint    circ_x       = 0;
	longint    circ_y       = 0;
	longint    ctr_x        = 0;
	longint    ctr_y        = 0;
	longint    circ_radius  = 0;
	logic [GLYPH_W-1:0] circ_glyph = '0;
	logic [COLOR_W-1:0] circ_fg    = '0;
	logic [COLOR_W-1:0] circ_bg    = '0;

	cell_req_t pending_cells[$];

	bit tx_steady   = 1'b0;
	bit rx_steady   = 1'b0;
	int stall_left  = 0;
	int cycle_count = 0;
	int mismatches  = 0;
	int n_starts    = 0;
	int n_steps     = 0;
	int n_idle      = 0;
	int n_checked   = 0;
	int n_written   = 0;
	int n_finishing = 0;

	circle_octant_rasterizer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// Hard limit on the length of the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t: run stopped at the cycle limit, %0d requests outstanding",
				$time, pending_cells.size());
			$display("tb_circle_octant_rasterizer: errors");
			$finish;
		end
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [IN_TDATA_W-1:0] pack_request(logic [COORD_W-1:0] cx,
		logic [COORD_W-1:0] cy, logic [RADIUS_W-1:0] rad, logic [GLYPH_W-1:0] gl,
		logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg);
		return IN_TDATA_W'({bg, fg, gl, rad, cy, cx});
	endfunction

	// One mirrored cell: linear index with only the whole-screen bound applied.
	function automatic cell_req_t mirror_cell(longint col, longint row, bit fin);
		longint    lin;
		longint    bound;
		cell_req_t c;
		lin     = row * longint'(scr_width) + col;
		bound   = longint'(scr_width) * longint'(scr_height);
		c.wr    = (lin >= 0) && (lin < bound);
		c.idx   = c.wr ? lin[INDEX_W-1:0] : '0;
		c.glyph = circ_glyph;
		c.fg    = circ_fg;
		c.bg    = circ_bg;
		c.tail  = 1'b0;
		c.fin   = fin;
		return c;
	endfunction

	// Update the circle state for one accepted request and queue its cells.
	task automatic predict_request(logic cmd, logic [IN_TDATA_W-1:0] data);
		cell_req_t ring[8];
		cell_req_t dead;
		longint    x;
		longint    y;
		bit        fin;
		if (cmd == CMD_START) begin
			ctr_x       = longint'($signed(data[11:0]));
			ctr_y       = longint'($signed(data[23:12]));
			circ_radius = longint'(data[33:24]);
			circ_glyph  = data[41:34];
			circ_fg     = data[65:42];
			circ_bg     = data[89:66];
			circ_x      = 0;
			circ_y      = circ_radius;
			circ_active = circ_radius > 0;
			n_starts++;
		end else if (!circ_active) begin
			// A step with no circle in progress gives one empty request.
			dead      = '0;
			dead.tail = 1'b1;
			dead.fin  = 1'b1;
			pending_cells.push_back(dead);
			n_idle++;
		end else begin
			x = circ_x;
			y = circ_y;
			if (x * x + (y - 1) * (y - 1) < circ_radius * circ_radius) begin
				circ_x = x + 1;
				fin    = circ_x >= circ_y;
			end else begin
				circ_y = y - 1;
				fin    = circ_y < 0;
			end
			if (fin)
				circ_active = 1'b0;
			ring[0] = mirror_cell(ctr_x + 2 * x, ctr_y + y, fin);
			ring[1] = mirror_cell(ctr_x + 2 * x, ctr_y - y, fin);
			ring[2] = mirror_cell(ctr_x - 2 * x, ctr_y + y, fin);
			ring[3] = mirror_cell(ctr_x - 2 * x, ctr_y - y, fin);
			ring[4] = mirror_cell(ctr_x + 2 * y, ctr_y + x, fin);
			ring[5] = mirror_cell(ctr_x + 2 * y, ctr_y - x, fin);
			ring[6] = mirror_cell(ctr_x - 2 * y, ctr_y + x, fin);
			ring[7] = mirror_cell(ctr_x - 2 * y, ctr_y - x, fin);
			ring[7].tail = 1'b1;
			foreach (ring[k])
				pending_cells.push_back(ring[k]);
			n_steps++;
		end
	endtask

	// Present one request after an optional gap and hold it until accepted.
	task automatic send_request(logic cmd, logic [IN_TDATA_W-1:0] data);
		int gap;
		gap = tx_steady ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = cmd;
		s_axis_tdata  = data;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_request(cmd, data);
	endtask

	// Stop sending and let every expected request come out.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_cells.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int value);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wdata = value[DIM_W-1:0];
		@(negedge clk);
		cfg_wr_en = 1'b0;
		if (idx == REG_SCREEN_WIDTH)
			scr_width = value;
		else
			scr_height = value;
	endtask

	task automatic set_screen(int w, int h);
		drain();
		write_reg(REG_SCREEN_WIDTH, w);
		write_reg(REG_SCREEN_HEIGHT, h);
	endtask

	task automatic send_start(int cx, int cy, int rad, int gl, int fg, int bg);
		send_request(CMD_START, pack_request(COORD_W'(cx), COORD_W'(cy), RADIUS_W'(rad),
			GLYPH_W'(gl), COLOR_W'(fg), COLOR_W'(bg)));
	endtask

	task automatic send_step();
		send_request(CMD_STEP, pack_request(COORD_W'($urandom), COORD_W'($urandom),
			RADIUS_W'($urandom), GLYPH_W'($urandom), COLOR_W'($urandom),
			COLOR_W'($urandom)));
	endtask

	// Mostly whole circles with random content, some cut short, plus noise.
	task automatic run_random_circles(int n_items);
		int sent;
		int cap;
		int steps;
		int roll;
		int rad;
		int cx;
		int cy;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0)
				tx_steady = !tx_steady;
			if ($urandom_range(0, 9) == 0)
				rx_steady = !rx_steady;
			if ($urandom_range(0, 99) < 85) begin
				roll = $urandom_range(0, 99);
				if (roll < 70)
					rad = $urandom_range(1, 12);
				else if (roll < 90)
					rad = $urandom_range(13, 40);
				else
					rad = $urandom_range(0, 1023);
				if ($urandom_range(0, 99) < 70) begin
					cx = $urandom_range(0, (scr_width > 0) ? scr_width - 1 : 0);
					cy = $urandom_range(0, (scr_height > 0) ? scr_height - 1 : 0);
				end else begin
					cx = $urandom;
					cy = $urandom;
				end
				send_start(cx, cy, rad, $urandom, $urandom, $urandom);
				sent++;
				cap   = $urandom_range(4, 40);
				steps = 0;
				while (circ_active && steps < cap && sent < n_items) begin
					send_step();
					steps++;
					sent++;
				end
				if ($urandom_range(0, 3) == 0 && sent < n_items) begin
					send_step();
					sent++;
				end
			end else begin
				send_request($urandom_range(0, 1) ? CMD_STEP : CMD_START,
					pack_request(COORD_W'($urandom), COORD_W'($urandom),
						RADIUS_W'($urandom), GLYPH_W'($urandom), COLOR_W'($urandom),
						COLOR_W'($urandom)));
				sent++;
			end
		end
	endtask

	// Steps with no circle in progress, including after a zero radius start.
	task automatic test_idle_steps();
		send_step();
		send_start(5, 5, 0, 8'h2A, 24'h123456, 24'h654321);
		send_step();
	endtask

	// Field extremes, a one-step circle, and small circles that wrap across rows.
	task automatic test_directed_circles();
		send_start(-2048, 2047, 1023, 8'hFF, 24'hFFFFFF, 24'h000000);
		repeat (3) send_step();
		send_start(2047, -2048, 1, 8'h00, 24'h000000, 24'hFFFFFF);
		repeat (2) send_step();
		send_start(0, 3, 3, 8'h41, 24'hA5A5A5, 24'h5A5A5A);
		while (circ_active)
			send_step();
		send_step();
		send_start(79, 24, 2, 8'h7E, 24'h00FF00, 24'hFF00FF);
		while (circ_active)
			send_step();
		send_step();
	endtask

	// Smallest, largest and empty screens.
	task automatic test_screen_extremes();
		set_screen(1, 1);
		run_random_circles(PHASE_ITEMS);
		set_screen(1023, 1023);
		run_random_circles(PHASE_ITEMS);
		set_screen(0, 25);
		run_random_circles(PHASE_ITEMS);
		set_screen(40, 0);
		run_random_circles(PHASE_ITEMS);
	endtask

	// Random screen sizes, then the reset size again.
	task automatic test_random_traffic();
		repeat (2) begin
			set_screen($urandom_range(1, 1023), $urandom_range(1, 1023));
			run_random_circles(PHASE_ITEMS);
		end
		set_screen(80, 25);
		run_random_circles(PHASE_ITEMS);
	endtask

	// Sink side: random stalls, with steady stretches.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_axis_tready = 1'b0;
				stall_left--;
			end else begin
				m_axis_tready = 1'b1;
				if (!rx_steady && $urandom_range(0, 99) < 25)
					stall_left = pick_gap();
			end
		end
	end

	task automatic report_field(string name, longint want, longint got);
		$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
		mismatches++;
	endtask

	// Compare each accepted cell request with the oldest expectation.
	always @(posedge clk) begin
		cell_req_t got;
		cell_req_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.idx   = m_axis_tdata[19:0];
			got.wr    = m_axis_tdata[20];
			got.glyph = m_axis_tdata[28:21];
			got.fg    = m_axis_tdata[52:29];
			got.bg    = m_axis_tdata[76:53];
			got.tail  = m_axis_tlast;
			got.fin   = m_axis_tuser;
			if (pending_cells.size() == 0) begin
				$display("%0t: unexpected cell request, expected none, got index 0x%0h",
					$time, got.idx);
				mismatches++;
			end else begin
				want = pending_cells.pop_front();
				if (got.idx !== want.idx)
					report_field("cell_index", longint'(want.idx), longint'(got.idx));
				if (got.wr !== want.wr)
					report_field("write_enable", longint'(want.wr), longint'(got.wr));
				if (got.glyph !== want.glyph)
					report_field("out_glyph", longint'(want.glyph), longint'(got.glyph));
				if (got.fg !== want.fg)
					report_field("out_fg", longint'(want.fg), longint'(got.fg));
				if (got.bg !== want.bg)
					report_field("out_bg", longint'(want.bg), longint'(got.bg));
				if (got.tail !== want.tail)
					report_field("last", longint'(want.tail), longint'(got.tail));
				if (got.fin !== want.fin)
					report_field("done_res", longint'(want.fin), longint'(got.fin));
				n_checked++;
				if (want.wr)
					n_written++;
				if (want.fin)
					n_finishing++;
			end
		end
	end

	// Reset, then each test in turn.
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser  = CMD_START;
		s_axis_tdata  = '0;
		cfg_wr_en     = 1'b0;
		cfg_index     = REG_SCREEN_WIDTH;
		cfg_wdata     = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_steps();
		test_directed_circles();
		test_screen_extremes();
		test_random_traffic();
		drain();

		$display("Covered %0d starts and %0d steps on a circle, %0d steps with none;",
			n_starts, n_steps, n_idle);
		$display("%0d cell requests checked, %0d inside the screen, %0d marking a finish.",
			n_checked, n_written, n_finishing);
		if (mismatches == 0 && pending_cells.size() == 0)
			$display("tb_circle_octant_rasterizer: clean");
		else
			$display("tb_circle_octant_rasterizer: errors");
		$finish;
	end

endmodule
